// ===== src/lkv_pkg.sv =====
`timescale 1ns / 1ps
package lkv_pkg;

	// stream and register port widths
	localparam int FIELD_W    = 32;
	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_W      = 5;
	localparam int OCC_W      = 5;
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	// output field positions inside m_tdata
	localparam int OUT_HIT_LSB = 0;
	localparam int OUT_RD_LSB  = 1;
	localparam int OUT_EV_LSB  = 33;
	localparam int OUT_OCC_LSB = 34;

	typedef enum logic [1:0] {
		KIND_GET    = 2'd0,
		KIND_PUT    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_DONE
	} state_t;

	// how the rank sweep rewrites the recency order
	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_TOUCH,
		UPD_FILL,
		UPD_DROP
	} upd_mode_t;

	typedef struct packed {
		logic load_req;
		logic sweep_clr;
		logic scan_en;
		logic decide;
		logic upd_en;
		logic load_result;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic need_update;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== src/lkv_ram.sv =====
`timescale 1ns / 1ps
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/lkv_ctrl.sv =====
`timescale 1ns / 1ps
module lkv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output lkv_pkg::ctrl_cmd_t cmd,
	input  lkv_pkg::ctrl_sts_t sts
);

	import lkv_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.sweep_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = sts.need_update ? ST_UPDATE : ST_DONE;
			end
			ST_UPDATE: begin
				if (sts.sweep_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.load_req  = s_tvalid;
				cmd.sweep_clr = s_tvalid;
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			ST_DECIDE: begin
				cmd.decide    = 1'b1;
				cmd.sweep_clr = 1'b1;
			end
			ST_UPDATE: begin
				cmd.upd_en = 1'b1;
			end
			ST_DONE: begin
				cmd.load_result = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== src/lkv_datapath.sv =====
`timescale 1ns / 1ps
module lkv_datapath #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkv_pkg::ctrl_cmd_t            cmd,
	output lkv_pkg::ctrl_sts_t            sts,
	input  logic [lkv_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [lkv_pkg::IN_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lkv_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                          cfg_we,
	input  logic [lkv_pkg::CFG_W-1:0]     cfg_wdata
);

	import lkv_pkg::*;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int RANK_W = IDX_W;
	localparam int KW     = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
	localparam int VW     = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
	localparam int CW     = (CNT_W > OCC_W) ? CNT_W : OCC_W;
	localparam logic [CNT_W-1:0] N_CNT = CNT_W'(ENTRIES);
	localparam logic [CW-1:0]    N_CW  = CW'(ENTRIES);

	// request and configuration
	kind_t             kind_q;
	logic [KW-1:0]     key_q;
	logic [VW-1:0]     val_q;
	logic [CFG_W-1:0]  cap_q;

	// table state
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   used_q;

	// sweep
	logic [CNT_W-1:0]   cnt_q;
	logic               issue;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               ent_v;

	// memory ports
	logic [KW-1:0]      key_rd;
	logic [RANK_W-1:0]  rank_rd;
	logic [VW-1:0]      val_rd;
	logic               rank_we;
	logic [RANK_W-1:0]  rank_wd;
	logic               key_we;
	logic               val_we;

	// scan results
	logic               match_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic [RANK_W-1:0]  match_rank_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               old_q;
	logic [IDX_W-1:0]   old_idx_q;
	logic [RANK_W-1:0]  old_rank_q;

	// decision
	upd_mode_t          mode_d, mode_q;
	logic [IDX_W-1:0]   tgt_d, tgt_q;
	logic [RANK_W-1:0]  ref_d, ref_q;
	logic               hit_d, hit_q;
	logic               evict_d, evict_q;
	logic               get_hit_q;
	logic [CNT_W-1:0]   used_d;
	logic               set_valid, clr_valid;
	logic [CW-1:0]      cap_x, cap_eff, used_x, occ_x;
	logic               full;

	// result
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_DATA_W-1:0] out_data_d;
	logic [FIELD_W-1:0]    rd_out;

	// request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NOP;
			key_q  <= '0;
			val_q  <= '0;
		end else if (cmd.load_req) begin
			kind_q <= kind_t'(s_tuser);
			key_q  <= s_tdata[KW-1:0];
			val_q  <= s_tdata[FIELD_W +: VW];
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// sweep counter, one entry a cycle, read data registered in the memories
	assign issue = (cmd.scan_en || cmd.upd_en) && (cnt_q != N_CNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.sweep_clr) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (issue) cnt_q <= cnt_q + 1'b1;
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
	end

	assign ent_v           = valid_q[idx_s1];
	assign sts.sweep_done  = (cnt_q == N_CNT) && !vld_s1;

	// key, value and rank stores
	lkv_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (tgt_d),
		.wdata (key_q),
		.re    (issue),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (key_rd)
	);

	lkv_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (tgt_d),
		.wdata (val_q),
		.re    (1'b1),
		.raddr (tgt_q),
		.rdata (val_rd)
	);

	lkv_ram #(.WIDTH(RANK_W), .DEPTH(ENTRIES)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (idx_s1),
		.wdata (rank_wd),
		.re    (issue),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (rank_rd)
	);

	// scan: matching entry, first free entry, least recent entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
			old_q   <= 1'b0;
		end else if (cmd.load_req) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
			old_q   <= 1'b0;
		end else if (cmd.scan_en && vld_s1) begin
			if (ent_v && (key_rd == key_q) && !match_q) begin
				match_q <= 1'b1;
			end
			if (!ent_v && !free_q) begin
				free_q <= 1'b1;
			end
			if (ent_v && (!old_q || (rank_rd > old_rank_q))) begin
				old_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_en && vld_s1) begin
			if (ent_v && (key_rd == key_q) && !match_q) begin
				match_idx_q  <= idx_s1;
				match_rank_q <= rank_rd;
			end
			if (!ent_v && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (ent_v && (!old_q || (rank_rd > old_rank_q))) begin
				old_idx_q  <= idx_s1;
				old_rank_q <= rank_rd;
			end
		end
	end

	// effective capacity, zero acts as one and large values as the table size
	assign cap_x  = CW'(cap_q);
	assign used_x = CW'(used_q);
	always_comb begin
		priority if (cap_x == '0) begin
			cap_eff = CW'(1);
		end else if (cap_x > N_CW) begin
			cap_eff = N_CW;
		end else begin
			cap_eff = cap_x;
		end
	end
	assign full = used_x >= cap_eff;

	// decide the operation from the scan results
	always_comb begin
		mode_d    = UPD_NONE;
		tgt_d     = match_idx_q;
		ref_d     = match_rank_q;
		hit_d     = 1'b0;
		evict_d   = 1'b0;
		used_d    = used_q;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		key_we    = 1'b0;
		val_we    = 1'b0;
		unique case (kind_q)
			KIND_GET: begin
				hit_d = match_q;
				if (match_q) mode_d = UPD_TOUCH;
			end
			KIND_PUT: begin
				hit_d = match_q;
				priority if (match_q) begin
					mode_d = UPD_TOUCH;
					val_we = cmd.decide;
				end else if (!full && free_q) begin
					mode_d    = UPD_FILL;
					tgt_d     = free_idx_q;
					used_d    = used_q + 1'b1;
					set_valid = 1'b1;
					key_we    = cmd.decide;
					val_we    = cmd.decide;
				end else if (full && old_q) begin
					// eviction plus refill ranks like a touch of the oldest
					mode_d  = UPD_TOUCH;
					tgt_d   = old_idx_q;
					ref_d   = old_rank_q;
					evict_d = 1'b1;
					key_we  = cmd.decide;
					val_we  = cmd.decide;
				end else if (free_q) begin
					mode_d    = UPD_FILL;
					tgt_d     = free_idx_q;
					used_d    = used_q + 1'b1;
					set_valid = 1'b1;
					key_we    = cmd.decide;
					val_we    = cmd.decide;
				end else begin
					mode_d = UPD_NONE;
				end
			end
			KIND_REMOVE: begin
				hit_d = match_q;
				if (match_q) begin
					mode_d    = UPD_DROP;
					clr_valid = 1'b1;
					if (used_q != '0) used_d = used_q - 1'b1;
				end
			end
			KIND_NOP: begin
				mode_d = UPD_NONE;
			end
			default: begin
				mode_d = UPD_NONE;
			end
		endcase
	end

	assign sts.need_update = mode_d != UPD_NONE;

	// commit the decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			used_q    <= '0;
			mode_q    <= UPD_NONE;
			hit_q     <= 1'b0;
			evict_q   <= 1'b0;
			get_hit_q <= 1'b0;
		end else if (cmd.decide) begin
			if (set_valid) valid_q[tgt_d] <= 1'b1;
			if (clr_valid) valid_q[tgt_d] <= 1'b0;
			used_q    <= used_d;
			mode_q    <= mode_d;
			hit_q     <= hit_d;
			evict_q   <= evict_d;
			get_hit_q <= (kind_q == KIND_GET) && match_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			tgt_q <= tgt_d;
			ref_q <= ref_d;
		end
	end

	// rank sweep rewrite
	always_comb begin
		rank_we = 1'b0;
		rank_wd = rank_rd;
		if (cmd.upd_en && vld_s1) begin
			if (idx_s1 == tgt_q) begin
				if (mode_q != UPD_DROP) begin
					rank_we = 1'b1;
					rank_wd = '0;
				end
			end else if (ent_v) begin
				unique case (mode_q)
					UPD_TOUCH: begin
						if (rank_rd < ref_q) begin
							rank_we = 1'b1;
							rank_wd = rank_rd + 1'b1;
						end
					end
					UPD_FILL: begin
						rank_we = 1'b1;
						rank_wd = rank_rd + 1'b1;
					end
					UPD_DROP: begin
						if (rank_rd > ref_q) begin
							rank_we = 1'b1;
							rank_wd = rank_rd - 1'b1;
						end
					end
					UPD_NONE: begin
						rank_we = 1'b0;
					end
					default: begin
						rank_we = 1'b0;
					end
				endcase
			end
		end
	end

	// result register
	assign rd_out       = get_hit_q ? FIELD_W'(val_rd) : '0;
	assign occ_x        = CW'(used_q);
	assign sts.out_free = !out_valid_q || m_tready;

	// packed result fields, padding stays zero
	always_comb begin
		out_data_d                        = '0;
		out_data_d[OUT_HIT_LSB]           = hit_q;
		out_data_d[OUT_RD_LSB +: FIELD_W] = rd_out;
		out_data_d[OUT_EV_LSB]            = evict_q;
		out_data_d[OUT_OCC_LSB +: OCC_W]  = occ_x[OCC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_data_q <= out_data_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	// fill count always matches the number of valid entries
	a_used_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(used_q))
		else $error("used count differs from valid entries");

	// a new result never overwrites one not yet taken
	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> (!out_valid_q || m_tready))
		else $error("result loaded over a pending result");

	// the rank sweep only runs for an operation that changes the order
	a_update_has_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_en |-> (mode_q != UPD_NONE))
		else $error("rank sweep without an update mode");

	// the entry made most recent is valid while its rank is written
	a_target_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd_en && vld_s1 && (idx_s1 == tgt_q) && (mode_q != UPD_DROP))
		|-> valid_q[idx_s1])
		else $error("most recent entry is not valid");
`endif

endmodule

// ===== src/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// flow: an accepted request is scanned, then decided, then sweeps the ranks again unless it
// changes nothing, and its result is loaded once the output register is free
// the block takes one request at a time, the next only after the result is loaded; the key scan
// and the rank rewrite each sweep the key and rank memories one entry per cycle
// reset: arst_n clears all entries, the fill count and the result valid flag; capacity is 16
module lru_key_value_cache #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// key [31:0], value [63:32]
	input  logic [lkv_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind [1:0]
	input  logic [lkv_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// hit [0], read_value [32:1], evicted [33], occupancy [38:34], zero [39]
	output logic [lkv_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic [lkv_pkg::CFG_W-1:0]      cfg_wdata
);

	import lkv_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer
	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// table, sweep and result datapath
	lkv_datapath #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

endmodule

// ===== verif/lru_key_value_cache_tb.sv =====
`timescale 1ns / 1ps
module lru_key_value_cache_tb;
	import lkv_pkg::*;

	localparam int SLOTS = 16;
	localparam int ITEMS_PER_PHASE = 43;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 80;

	// predicts each reply from a shadow copy of the table and its recency order
	class lru_cache_predictor;
		typedef struct {
			bit        hit;
			bit [31:0] read_value;
			bit        evicted;
			bit [4:0]  occupancy;
		} reply_t;

		reply_t    pending[$];
		bit [31:0] slot_key[SLOTS];
		bit [31:0] slot_value[SLOTS];
		bit        slot_valid[SLOTS];
		int        slot_rank[SLOTS];
		int        used;
		bit [4:0]  capacity;
		int        errors;
		int        replies;
		int        hits;
		int        evictions;
		int        kinds_seen[4];

		function new();
			capacity = CAP_RESET;
			used = 0;
			foreach (slot_valid[i]) begin
				slot_valid[i] = 0;
				slot_rank[i] = 0;
			end
		endfunction

		function int find_slot(bit [31:0] key);
			foreach (slot_valid[i])
				if (slot_valid[i] && slot_key[i] == key)
					return i;
			return -1;
		endfunction

		function int first_free();
			foreach (slot_valid[i])
				if (!slot_valid[i])
					return i;
			return -1;
		endfunction

		function int least_recent();
			int best;
			best = -1;
			foreach (slot_valid[i])
				if (slot_valid[i] && (best < 0 || slot_rank[i] > slot_rank[best]))
					best = i;
			return best;
		endfunction

		// move an entry to the front, aging the ones that were ahead of it
		function void promote(int e);
			foreach (slot_valid[i])
				if (slot_valid[i] && slot_rank[i] < slot_rank[e])
					slot_rank[i]++;
			slot_rank[e] = 0;
		endfunction

		// free an entry and close the gap it leaves in the order
		function void retire(int e);
			foreach (slot_valid[i])
				if (slot_valid[i] && slot_rank[i] > slot_rank[e])
					slot_rank[i]--;
			slot_valid[e] = 0;
			slot_rank[e] = 0;
		endfunction

		function void note_request(kind_t kind, bit [31:0] key, bit [31:0] value);
			reply_t r;
			int     e;
			int     cap;
			r = '{0, 0, 0, 0};
			cap = capacity;
			if (cap < 1)
				cap = 1;
			if (cap > SLOTS)
				cap = SLOTS;
			kinds_seen[int'(kind)]++;
			e = find_slot(key);
			case (kind)
				KIND_GET: begin
					if (e >= 0) begin
						r.hit = 1;
						r.read_value = slot_value[e];
						promote(e);
					end
				end
				KIND_PUT: begin
					if (e >= 0) begin
						r.hit = 1;
						slot_value[e] = value;
						promote(e);
					end else begin
						// fill a free slot below capacity, otherwise replace the oldest
						if (used < cap) begin
							e = first_free();
							if (e >= 0)
								used++;
						end else begin
							e = least_recent();
							if (e >= 0) begin
								retire(e);
								r.evicted = 1;
							end else begin
								e = first_free();
								if (e >= 0)
									used++;
							end
						end
						if (e >= 0) begin
							foreach (slot_valid[i])
								if (slot_valid[i])
									slot_rank[i]++;
							slot_key[e] = key;
							slot_value[e] = value;
							slot_valid[e] = 1;
							slot_rank[e] = 0;
						end
					end
				end
				KIND_REMOVE: begin
					if (e >= 0) begin
						r.hit = 1;
						retire(e);
						if (used > 0)
							used--;
					end
				end
				default: ;
			endcase
			r.occupancy = used[4:0];
			if (r.hit)
				hits++;
			if (r.evicted)
				evictions++;
			pending.push_back(r);
		endfunction

		function void flag(string field, logic [39:0] exp, logic [39:0] act);
			errors++;
			if (errors <= 10)
				$display("mismatch on reply %0d, %s: expected %h, got %h",
					replies, field, exp, act);
		endfunction

		function void check_reply(logic [OUT_DATA_W-1:0] d);
			reply_t r;
			replies++;
			if (pending.size() == 0) begin
				flag("unexpected reply", '0, d);
				return;
			end
			r = pending.pop_front();
			if (d[OUT_HIT_LSB] !== r.hit)
				flag("hit", r.hit, d[OUT_HIT_LSB]);
			if (d[OUT_RD_LSB +: FIELD_W] !== r.read_value)
				flag("read_value", r.read_value, d[OUT_RD_LSB +: FIELD_W]);
			if (d[OUT_EV_LSB] !== r.evicted)
				flag("evicted", r.evicted, d[OUT_EV_LSB]);
			if (d[OUT_OCC_LSB +: OCC_W] !== r.occupancy)
				flag("occupancy", r.occupancy, d[OUT_OCC_LSB +: OCC_W]);
			if (d[OUT_DATA_W-1] !== 1'b0)
				flag("padding", '0, d[OUT_DATA_W-1]);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	logic [CFG_W-1:0]      cfg_wdata;

	lru_cache_predictor sb = new();
	bit steady;
	bit hold_req;
	int rx_gap;
	int idle_count;
	int cap_writes;

	lru_key_value_cache #(
		.ENTRIES(SLOTS),
		.KEY_BITS(32),
		.VALUE_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 2 ns clock
	initial clk = 0;
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	// receiver: random back-pressure plus one long hold-off on request
	initial begin
		m_tready = 0;
		rx_gap = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready = 0;
				repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready = 0;
			end else begin
				m_tready = 1;
				if (!steady && $urandom_range(0, 99) < 30)
					rx_gap = pick_gap();
			end
		end
	end

	// sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(kind_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
			if (m_tvalid && m_tready)
				sb.check_reply(m_tdata);
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles", STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_request(kind_t kind, bit [31:0] key, bit [31:0] value);
		@(negedge clk);
		s_tvalid = 1;
		s_tuser = kind;
		s_tdata = {value, key};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic idle_sender(int n);
		@(negedge clk);
		s_tvalid = 0;
		s_tdata = {$urandom, $urandom};
		s_tuser = 2'($urandom_range(0, 3));
		repeat (n - 1) @(negedge clk);
	endtask

	// hold the sender until every reply is back
	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(bit [4:0] v);
		drain();
		repeat (4) @(negedge clk);
		cfg_we = 1;
		cfg_wdata = v;
		sb.capacity = v;
		@(negedge clk);
		cfg_we = 0;
		cap_writes++;
	endtask

	initial begin
		int        cap_plan[10];
		bit [31:0] pool[40];
		int        pool_n;
		int        eff;
		int        r;
		kind_t     kind;
		bit [31:0] key;
		cap_writes = 0;
		steady = 0;
		hold_req = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		arst_n = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;

		// empty table, extreme keys and values, update and remove at reset capacity
		send_request(KIND_GET, 32'h0, 32'h0);
		send_request(KIND_REMOVE, 32'h1234_5678, 32'hFFFF_FFFF);
		send_request(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(KIND_PUT, 32'h0, 32'h0);
		send_request(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(KIND_GET, 32'hFFFF_FFFF, 32'h0);
		send_request(KIND_GET, 32'h0, 32'hFFFF_FFFF);
		send_request(KIND_PUT, 32'h0, 32'hA5A5_A5A5);
		send_request(KIND_GET, 32'h0, 32'h0);
		send_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);
		send_request(KIND_GET, 32'hFFFF_FFFF, 32'h0);

		// two entries: a get protects its key, the other one is evicted
		write_capacity(5'd2);
		send_request(KIND_PUT, 32'h1, 32'h1111_1111);
		send_request(KIND_PUT, 32'h2, 32'h2222_2222);
		send_request(KIND_GET, 32'h1, 32'h0);
		send_request(KIND_PUT, 32'h3, 32'h3333_3333);
		send_request(KIND_GET, 32'h2, 32'h0);
		send_request(KIND_GET, 32'h1, 32'h0);
		send_request(KIND_PUT, 32'h8000_0000, 32'h5555_AAAA);

		// zero capacity acts as one, below the current fill
		write_capacity(5'd0);
		send_request(KIND_PUT, 32'h7, 32'h7777_7777);
		send_request(KIND_PUT, 32'h8, 32'h8888_8888);
		send_request(KIND_REMOVE, 32'h8, 32'h0);
		send_request(KIND_GET, 32'h7, 32'h0);

		// random phases over several capacities, out-of-range ones included
		cap_plan = '{31, 16, 1, 4, 17, 0, 8, 3, 16, 5};
		cap_plan[9] = $urandom_range(1, 16);
		for (int ph = 0; ph < 10; ph++) begin
			write_capacity(cap_plan[ph][4:0]);
			steady = (ph == 2);
			eff = cap_plan[ph] < 1 ? 1 : (cap_plan[ph] > SLOTS ? SLOTS : cap_plan[ph]);
			// a key set a bit larger than capacity gives both hits and evictions
			pool_n = eff + $urandom_range(1, eff + 2);
			for (int i = 0; i < pool_n; i++)
				pool[i] = $urandom;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 4 && n == 8)
					hold_req = 1;
				r = $urandom_range(0, 99);
				kind = r < 40 ? KIND_PUT : r < 75 ? KIND_GET : r < 95 ? KIND_REMOVE : KIND_NOP;
				if ($urandom_range(0, 99) < 85)
					key = pool[$urandom_range(0, pool_n - 1)];
				else
					key = $urandom;
				send_request(kind, key, $urandom);
				if (!steady) begin
					r = $urandom_range(0, 99);
					if (r < 4)
						drain();
					else if (r < 29)
						idle_sender(pick_gap());
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("requests: %0d get, %0d put, %0d remove, %0d no-op; %0d hits, %0d evictions",
			sb.kinds_seen[0], sb.kinds_seen[1], sb.kinds_seen[2], sb.kinds_seen[3],
			sb.hits, sb.evictions);
		$display("%0d replies checked over %0d capacity settings, %0d mismatches",
			sb.replies, cap_writes, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
